FILE: rtl/ncc_pkg.sv
// ----------------------------------------------------------------------------
// ncc_pkg
// shared constants and types of the nearest centroid threshold classifier
// ----------------------------------------------------------------------------
package ncc_pkg;

    localparam int MAX_CLUSTERS = 16;
    localparam int MAX_FEATURES = 32;
    localparam int VALUE_BITS   = 16;

    localparam int CLUSTER_W = $clog2(MAX_CLUSTERS);
    localparam int FEATURE_W = $clog2(MAX_FEATURES);
    localparam int ADDR_W    = CLUSTER_W + FEATURE_W;
    localparam int NC_W      = 5;
    localparam int NF_W      = 6;
    localparam int COUNT_W   = 6;
    localparam int DIST_W    = 48;
    localparam int DIFF_W    = VALUE_BITS + 1;
    localparam int MAG_W     = VALUE_BITS;
    localparam int PROD_W    = 2 * VALUE_BITS;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 64;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [1:0] REG_CLUSTER_COUNT   = 2'd0;
    localparam logic [1:0] REG_FEATURE_COUNT   = 2'd1;
    localparam logic [1:0] REG_EPSILON_SQUARED = 2'd2;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_OBSERVE = 1'b1;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

FILE: rtl/nearest_centroid_threshold_classifier_unit.sv
// ----------------------------------------------------------------------------
// nearest_centroid_threshold_classifier_unit
// nearest centroid classifier with squared euclidean distance and noise limit
// ----------------------------------------------------------------------------
// Load beats (func 0) write one centroid element into a 512 x 16 centroid
// memory. Observation beats (func 1) are stored in a 32 x 16 buffer memory;
// both are taken only while the block is idle. After the beat marked last, the
// block walks every centroid in use, element by element, through one
// subtract-and-square multiply-accumulate fed from the two memories, and the
// input stalls while the walk runs through the memory read, square and
// accumulate registers; the result is then loaded into the output register.
// A length error or an empty centroid set skips the walk and goes straight
// to the result. A result still waiting in the output register holds the
// block until it is taken. The memories need no clearing after reset;
// centroid elements must be loaded before they are used. A finished result
// waits in the output register while load and observation beats are taken
// again.
module nearest_centroid_threshold_classifier_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_func,
    input  logic [ncc_pkg::CLUSTER_W-1:0]        i_cluster_slot,
    input  logic [ncc_pkg::FEATURE_W-1:0]        i_feature_slot,
    input  logic signed [ncc_pkg::VALUE_BITS-1:0] i_value,
    input  logic                                 i_last_element,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [ncc_pkg::CLUSTER_W-1:0]        o_cluster_index,
    output logic                                 o_is_noise,
    output logic                                 o_status,
    output logic [ncc_pkg::DIST_W-1:0]           o_best_distance_squared,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ncc_pkg::APB_AW-1:0]           paddr,
    input  logic [ncc_pkg::APB_DW-1:0]           pwdata,
    output logic [ncc_pkg::APB_DW-1:0]           prdata,
    output logic                                 pready
);
    import ncc_pkg::*;

    // configuration
    logic [NC_W-1:0]   r_cluster_count;
    logic [NF_W-1:0]   r_feature_count;
    logic [DIST_W-1:0] r_epsilon_squared;
    logic              cfg_we;

    // control
    t_state             r_state;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               in_beat;
    logic               obs_beat;
    logic [NC_W-1:0]    nc;

    // issue stage
    logic                 r_issuing;
    logic [CLUSTER_W-1:0] r_c;
    logic [FEATURE_W-1:0] r_f;
    logic                 issue;
    logic                 iss_last_f;
    logic                 iss_last_c;

    // memories
    logic signed [VALUE_BITS-1:0] mem_cent [MAX_CLUSTERS*MAX_FEATURES];
    logic signed [VALUE_BITS-1:0] mem_obs  [MAX_FEATURES];
    logic signed [VALUE_BITS-1:0] r_cent_q;
    logic signed [VALUE_BITS-1:0] r_obs_q;

    // pipeline tags
    logic                 r_s1_valid, r_s1_first, r_s1_last_f, r_s1_last_c;
    logic [CLUSTER_W-1:0] r_s1_c;
    logic                 r_s2_valid, r_s2_first, r_s2_last_f, r_s2_last_c;
    logic [CLUSTER_W-1:0] r_s2_c;

    // arithmetic
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        diff_abs;
    logic [MAG_W-1:0]         mag;
    logic [PROD_W-1:0]        r_prod;
    logic [DIST_W-1:0]        r_acc;
    logic [DIST_W-1:0]        n_acc;

    // result
    logic [DIST_W-1:0]    r_best;
    logic [CLUSTER_W-1:0] r_best_c;
    logic                 r_res_status;
    logic                 r_res_nocl;
    logic                 res_noise;
    logic                 r_out_valid;
    logic                 out_load;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_count   <= NC_W'(0);
            r_feature_count   <= NF_W'(1);
            r_epsilon_squared <= DIST_W'(65536);
        end else if (cfg_we) begin
            unique case (paddr[4:3])
                REG_CLUSTER_COUNT:   r_cluster_count   <= pwdata[NC_W-1:0];
                REG_FEATURE_COUNT:   r_feature_count   <= pwdata[NF_W-1:0];
                REG_EPSILON_SQUARED: r_epsilon_squared <= pwdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_CLUSTER_COUNT:   prdata = APB_DW'(r_cluster_count);
            REG_FEATURE_COUNT:   prdata = APB_DW'(r_feature_count);
            REG_EPSILON_SQUARED: prdata = APB_DW'(r_epsilon_squared);
            default:             prdata = '0;
        endcase
    end

    // input beats
    assign o_ready  = (r_state == S_IDLE);
    assign in_beat  = i_valid & o_ready;
    assign obs_beat = in_beat & (i_func == FUNC_OBSERVE);
    assign n_count  = (r_count == COUNT_MAX) ? r_count : r_count + COUNT_W'(1);
    assign nc       = (r_cluster_count > NC_W'(MAX_CLUSTERS))
                      ? NC_W'(MAX_CLUSTERS) : r_cluster_count;

    assign issue      = (r_state == S_RUN) & r_issuing;
    assign iss_last_f = ({1'b0, r_f} == NF_W'(r_feature_count - NF_W'(1)));
    assign iss_last_c = ({1'b0, r_c} == NC_W'(nc - NC_W'(1)));

    // centroid and observation memories
    always_ff @(posedge i_clk) begin
        if (in_beat && i_func == FUNC_LOAD) begin
            mem_cent[{i_cluster_slot, i_feature_slot}] <= i_value;
        end
        if (issue) begin
            r_cent_q <= mem_cent[{r_c, r_f}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (obs_beat && r_count < COUNT_W'(MAX_FEATURES)) begin
            mem_obs[r_count[FEATURE_W-1:0]] <= i_value;
        end
        if (issue) begin
            r_obs_q <= mem_obs[r_f];
        end
    end

    // subtract and square
    assign diff     = DIFF_W'(r_obs_q) - DIFF_W'(r_cent_q);
    assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign mag      = diff_abs[MAG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_prod <= mag * mag;
        end
    end

    assign n_acc = r_s2_first ? DIST_W'(r_prod) : r_acc + DIST_W'(r_prod);

    always_ff @(posedge i_clk) begin
        r_s1_first  <= (r_f == FEATURE_W'(0));
        r_s1_last_f <= iss_last_f;
        r_s1_last_c <= iss_last_c;
        r_s1_c      <= r_c;
        r_s2_first  <= r_s1_first;
        r_s2_last_f <= r_s1_last_f;
        r_s2_last_c <= r_s1_last_c;
        r_s2_c      <= r_s1_c;
        if (r_s2_valid) begin
            r_acc <= n_acc;
        end
    end

    assign out_load = (r_state == S_DONE) & (~r_out_valid | i_ready);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_issuing    <= 1'b0;
            r_c          <= '0;
            r_f          <= '0;
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_res_status <= STATUS_OK;
            r_res_nocl   <= 1'b0;
        end else begin
            r_s1_valid <= issue;
            r_s2_valid <= r_s1_valid;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (obs_beat) begin
                        if (i_last_element) begin
                            r_count <= '0;
                            r_c     <= '0;
                            r_f     <= '0;
                            if (n_count != COUNT_W'(r_feature_count)
                                || r_feature_count > NF_W'(MAX_FEATURES)) begin
                                r_res_status <= STATUS_LENGTH;
                                r_res_nocl   <= 1'b0;
                                r_best       <= '0;
                                r_state      <= S_DONE;
                            end else if (nc == NC_W'(0)) begin
                                r_res_status <= STATUS_OK;
                                r_res_nocl   <= 1'b1;
                                r_best       <= '0;
                                r_state      <= S_DONE;
                            end else begin
                                r_res_status <= STATUS_OK;
                                r_res_nocl   <= 1'b0;
                                r_issuing    <= 1'b1;
                                r_state      <= S_RUN;
                            end
                        end else begin
                            r_count <= n_count;
                        end
                    end
                end
                S_RUN: begin
                    if (issue) begin
                        if (iss_last_f) begin
                            r_f <= '0;
                            r_c <= r_c + CLUSTER_W'(1);
                            if (iss_last_c) begin
                                r_issuing <= 1'b0;
                            end
                        end else begin
                            r_f <= r_f + FEATURE_W'(1);
                        end
                    end
                    if (r_s2_valid && r_s2_last_f) begin
                        if (r_s2_c == CLUSTER_W'(0) || n_acc < r_best) begin
                            r_best   <= n_acc;
                            r_best_c <= r_s2_c;
                        end
                        if (r_s2_last_c) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register
    assign res_noise = r_res_nocl
                       | ((r_res_status == STATUS_OK) & (r_best > r_epsilon_squared));

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_status                <= r_res_status;
            o_is_noise              <= res_noise;
            o_best_distance_squared <= r_best;
            o_cluster_index         <= (res_noise || r_res_status == STATUS_LENGTH)
                                       ? CLUSTER_W'(0) : r_best_c;
        end
    end

    assign o_valid = r_out_valid;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the nearest centroid threshold classifier
// ----------------------------------------------------------------------------
// A directed table covers the reset settings, value extremes, the epsilon
// boundary, ties, clamped cluster counts and length errors. Randomised phases
// then stream centroid loads and observations under several register
// settings and handshake gap patterns, including a long output hold-off.
// Each result is checked against its table entry or a nearest-centroid predictor.
// ----------------------------------------------------------------------------
module tb;
    import ncc_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef struct packed {
        logic                  func;
        logic [CLUSTER_W-1:0]  cluster_slot;
        logic [FEATURE_W-1:0]  feature_slot;
        logic [VALUE_BITS-1:0] value;
        logic                  last_element;
    } t_beat;

    typedef struct packed {
        logic [CLUSTER_W-1:0] cluster_index;
        logic                 is_noise;
        logic                 status;
        logic [DIST_W-1:0]    distance;
    } t_result;

    typedef enum logic {ROW_BEAT, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        t_beat             b;
        logic [1:0]        reg_sel;
        logic [APB_DW-1:0] reg_val;
        logic              typed;
        t_result           want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_func;
    logic [CLUSTER_W-1:0]  i_cluster_slot;
    logic [FEATURE_W-1:0]  i_feature_slot;
    logic [VALUE_BITS-1:0] i_value;
    logic                  i_last_element;
    logic                  o_valid;
    logic                  i_ready;
    logic [CLUSTER_W-1:0]  o_cluster_index;
    logic                  o_is_noise;
    logic                  o_status;
    logic [DIST_W-1:0]     o_best_distance_squared;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    nearest_centroid_threshold_classifier_unit u_top (.*);

    // predictor state
    logic signed [VALUE_BITS-1:0] cent_mem [MAX_CLUSTERS][MAX_FEATURES];
    logic                         cent_written [MAX_CLUSTERS][MAX_FEATURES];
    logic signed [VALUE_BITS-1:0] obs_mem [MAX_FEATURES];
    logic [COUNT_W-1:0]           obs_count;
    logic [NC_W-1:0]              cfg_clusters;
    logic [NF_W-1:0]              cfg_features;
    logic [DIST_W-1:0]            cfg_eps;

    t_result pending_results [$];
    t_row    dir_rows [$];

    int  send_idle;
    int  recv_stall;
    bit  hold_req;
    int  hold_left;
    int  quiet_cycles;
    int  errors;
    int  n_beats;
    int  n_stim;
    int  n_results;
    int  n_hits;
    int  n_noise;
    int  n_len_err;
    int  n_settings;

    always begin
        i_clk = 1'b0;
        #HALF_PERIOD;
        i_clk = 1'b1;
        #HALF_PERIOD;
    end

    function automatic int clamp_clusters();
        return (cfg_clusters > MAX_CLUSTERS) ? MAX_CLUSTERS : int'(cfg_clusters);
    endfunction

    function automatic t_beat mk_beat(input logic func, input int cs, input int fs,
                                      input logic [VALUE_BITS-1:0] value, input logic last);
        t_beat b;
        b.func         = func;
        b.cluster_slot = cs[CLUSTER_W-1:0];
        b.feature_slot = fs[FEATURE_W-1:0];
        b.value        = value;
        b.last_element = last;
        return b;
    endfunction

    // nearest centroid with noise limit; returns 1 when the beat yields a result
    function automatic bit classify(input t_beat b, output t_result r);
        int     nc;
        int     c;
        int     f;
        int     diff;
        longint acc;
        logic [DIST_W-1:0] best;
        r = '0;
        if (b.func == FUNC_LOAD) begin
            cent_mem[b.cluster_slot][b.feature_slot]     = b.value;
            cent_written[b.cluster_slot][b.feature_slot] = 1'b1;
            return 1'b0;
        end
        if (obs_count < MAX_FEATURES)
            obs_mem[obs_count[FEATURE_W-1:0]] = b.value;
        if (obs_count != COUNT_MAX)
            obs_count = obs_count + 1'b1;
        if (!b.last_element)
            return 1'b0;
        if (obs_count != cfg_features || cfg_features > MAX_FEATURES) begin
            obs_count = '0;
            r.status  = STATUS_LENGTH;
            return 1'b1;
        end
        obs_count = '0;
        nc = clamp_clusters();
        if (nc == 0) begin
            r.is_noise = 1'b1;
            return 1'b1;
        end
        best = DIST_MAX;
        for (c = 0; c < nc; c++) begin
            acc = 0;
            for (f = 0; f < int'(cfg_features); f++) begin
                diff = obs_mem[f] - cent_mem[c][f];
                acc += longint'(diff) * longint'(diff);
                if (acc > DIST_MAX)
                    acc = DIST_MAX;
            end
            if (c == 0 || acc < best) begin
                best            = acc[DIST_W-1:0];
                r.cluster_index = c[CLUSTER_W-1:0];
            end
        end
        r.distance = best;
        if (best > cfg_eps) begin
            r.is_noise      = 1'b1;
            r.cluster_index = '0;
        end
        return 1'b1;
    endfunction

    task automatic drive_beat(input t_beat b, input bit typed, input t_result want);
        t_result r;
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_func         <= b.func;
        i_cluster_slot <= b.cluster_slot;
        i_feature_slot <= b.feature_slot;
        i_value        <= b.value;
        i_last_element <= b.last_element;
        do @(posedge i_clk); while (!o_ready);
        if (classify(b, r))
            pending_results.push_back(typed ? want : r);
        n_beats++;
        @(negedge i_clk);
    endtask

    // centroid entries about to be read are loaded first if still unwritten
    task automatic send(input t_beat b, input bit typed, input t_result want);
        logic [COUNT_W-1:0] next_count;
        int nc;
        int c;
        int f;
        if (b.func == FUNC_OBSERVE && b.last_element) begin
            next_count = (obs_count == COUNT_MAX) ? obs_count : obs_count + 1'b1;
            nc = clamp_clusters();
            if (next_count == cfg_features && cfg_features <= MAX_FEATURES) begin
                for (c = 0; c < nc; c++)
                    for (f = 0; f < int'(cfg_features); f++)
                        if (!cent_written[c][f])
                            drive_beat(mk_beat(FUNC_LOAD, c, f, VALUE_BITS'($urandom),
                                               1'($urandom_range(1))),
                                       1'b0, '0);
            end
        end
        drive_beat(b, typed, want);
        n_stim++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [APB_DW-1:0] val);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_CLUSTER_COUNT:   cfg_clusters = val[NC_W-1:0];
            REG_FEATURE_COUNT:   cfg_features = val[NF_W-1:0];
            REG_EPSILON_SQUARED: cfg_eps      = val[DIST_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic dir_beat(input logic func, input int cs, input int fs,
                            input logic [VALUE_BITS-1:0] value, input logic last);
        t_row row;
        row       = '0;
        row.kind  = ROW_BEAT;
        row.b     = mk_beat(func, cs, fs, value, last);
        dir_rows.push_back(row);
    endtask

    task automatic dir_expect(input logic [VALUE_BITS-1:0] value, input int idx,
                              input logic noise, input logic status,
                              input logic [DIST_W-1:0] distance);
        t_row row;
        row                    = '0;
        row.kind               = ROW_BEAT;
        row.b                  = mk_beat(FUNC_OBSERVE, $urandom, $urandom, value, 1'b1);
        row.typed              = 1'b1;
        row.want.cluster_index = idx[CLUSTER_W-1:0];
        row.want.is_noise      = noise;
        row.want.status        = status;
        row.want.distance      = distance;
        dir_rows.push_back(row);
    endtask

    task automatic dir_reg(input logic [1:0] idx, input logic [APB_DW-1:0] val);
        t_row row;
        row         = '0;
        row.kind    = ROW_REG;
        row.reg_sel = idx;
        row.reg_val = val;
        dir_rows.push_back(row);
    endtask

    task automatic send_loads();
        int n;
        int i;
        int c;
        int f;
        int nc;
        int nf;
        logic [VALUE_BITS-1:0] v;
        n  = $urandom_range(4, 1);
        nc = (clamp_clusters() == 0) ? 1 : clamp_clusters();
        nf = (cfg_features == 0) ? 1 :
             (cfg_features > MAX_FEATURES) ? MAX_FEATURES : int'(cfg_features);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(1)) begin
                c = $urandom_range(MAX_CLUSTERS - 1);
                f = $urandom_range(MAX_FEATURES - 1);
            end else begin
                c = $urandom_range(nc - 1);
                f = $urandom_range(nf - 1);
            end
            // copies of other centroids make ties
            if ($urandom_range(3) == 0)
                v = cent_mem[$urandom_range(MAX_CLUSTERS - 1)][f];
            else
                v = VALUE_BITS'($urandom);
            send(mk_beat(FUNC_LOAD, c, f, v, 1'($urandom_range(1))), 1'b0, '0);
        end
    endtask

    task automatic send_observation(input int len, input bit with_last);
        int mode;
        int k;
        int f;
        int spread;
        logic [VALUE_BITS-1:0] v;
        mode   = $urandom_range(3);
        k      = (clamp_clusters() == 0) ? 0 : $urandom_range(clamp_clusters() - 1);
        spread = (mode == 1) ? 16 : 512;
        for (f = 0; f < len; f++) begin
            case (mode)
                0:       v = VALUE_BITS'($urandom);
                1, 2:    v = VALUE_BITS'(cent_mem[k][f % MAX_FEATURES]
                                         + $urandom_range(2 * spread) - spread);
                default: v = VALUE_BITS'($urandom_range(4) - 2);
            endcase
            send(mk_beat(FUNC_OBSERVE, $urandom, $urandom, v, with_last && f == len - 1),
                 1'b0, '0);
        end
    endtask

    task automatic run_random(input int n);
        int stop;
        int pick;
        int nf;
        stop = n_stim + n;
        while (n_stim < stop) begin
            pick = $urandom_range(99);
            nf   = (cfg_features == 0) ? 1 : int'(cfg_features);
            if (pick < 20) begin
                send_loads();
            end else if (pick < 82) begin
                send_observation(nf, 1'b1);
            end else if (pick < 90) begin
                send_observation($urandom_range(40, 1), 1'b1);
            end else if (pick < 95) begin
                send_observation($urandom_range(3, 1), 1'b0);
            end else if (pick < 97) begin
                send_observation($urandom_range(70, 64), 1'b1);
            end else begin
                // hold back until every result is out
                i_valid <= 1'b0;
                do @(negedge i_clk); while (pending_results.size() != 0);
            end
        end
    endtask

    task automatic run_phase(input int cc, input int fc, input logic [DIST_W-1:0] eps,
                             input int idle, input int stall, input bit hold, input int n);
        reg_write(REG_CLUSTER_COUNT, APB_DW'(cc));
        reg_write(REG_FEATURE_COUNT, APB_DW'(fc));
        reg_write(REG_EPSILON_SQUARED, APB_DW'(eps));
        send_idle  = idle;
        recv_stall = stall;
        hold_req   = hold;
        n_settings++;
        run_random(n);
    endtask

    // output side
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic check_field(input string what, input logic [DIST_W-1:0] want,
                               input logic [DIST_W-1:0] got);
        if (got !== want) begin
            $display("%0t mismatch %s: expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (o_status == STATUS_LENGTH)
                n_len_err++;
            else if (o_is_noise)
                n_noise++;
            else
                n_hits++;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: index %0d noise %0b status %0b distance %0d",
                         $time, o_cluster_index, o_is_noise, o_status,
                         o_best_distance_squared);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("cluster_index", want.cluster_index, o_cluster_index);
                check_field("is_noise", want.is_noise, o_is_noise);
                check_field("status", want.status, o_status);
                check_field("best_distance_squared", want.distance,
                            o_best_distance_squared);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t timeout: no beat for %0d cycles, %0d results outstanding",
                         $time, WATCHDOG_LIMIT, pending_results.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_func         = FUNC_LOAD;
        i_cluster_slot = '0;
        i_feature_slot = '0;
        i_value        = '0;
        i_last_element = 1'b0;
        i_ready        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle      = 0;
        recv_stall     = 0;
        hold_req       = 1'b0;
        hold_left      = 0;
        quiet_cycles   = 0;
        errors         = 0;
        n_beats        = 0;
        n_stim         = 0;
        n_results      = 0;
        n_hits         = 0;
        n_noise        = 0;
        n_len_err      = 0;
        n_settings     = 1;
        for (int c = 0; c < MAX_CLUSTERS; c++)
            for (int f = 0; f < MAX_FEATURES; f++) begin
                cent_mem[c][f]     = '0;
                cent_written[c][f] = 1'b0;
            end
        for (int f = 0; f < MAX_FEATURES; f++)
            obs_mem[f] = '0;
        obs_count    = '0;
        cfg_clusters = '0;
        cfg_features = 6'd1;
        cfg_eps      = 48'd65536;

        // reset settings: no clusters, one feature, epsilon squared of 65536
        dir_expect(16'h7fff, 0, 1'b1, STATUS_OK, 48'd0);
        dir_beat(FUNC_OBSERVE, 15, 31, 16'h8000, 1'b0);
        dir_expect(16'h0001, 0, 1'b0, STATUS_LENGTH, 48'd0);
        dir_beat(FUNC_LOAD, 15, 31, 16'h8000, 1'b1);
        dir_reg(REG_CLUSTER_COUNT, 1);
        dir_beat(FUNC_LOAD, 0, 0, 16'h7fff, 1'b0);
        dir_expect(16'h8000, 0, 1'b1, STATUS_OK, 48'd4294836225);
        dir_beat(FUNC_LOAD, 0, 0, 16'h0000, 1'b0);
        dir_expect(16'h0100, 0, 1'b0, STATUS_OK, 48'd65536);
        dir_expect(16'h0101, 0, 1'b1, STATUS_OK, 48'd66049);
        dir_reg(REG_CLUSTER_COUNT, 2);
        dir_beat(FUNC_LOAD, 1, 0, 16'h0000, 1'b0);
        dir_expect(16'h0000, 0, 1'b0, STATUS_OK, 48'd0);
        dir_beat(FUNC_LOAD, 1, 0, 16'h0005, 1'b1);
        dir_expect(16'h0005, 1, 1'b0, STATUS_OK, 48'd0);
        dir_reg(REG_EPSILON_SQUARED, 0);
        dir_expect(16'h0004, 0, 1'b1, STATUS_OK, 48'd1);
        dir_expect(16'h0005, 1, 1'b0, STATUS_OK, 48'd0);
        dir_reg(REG_FEATURE_COUNT, 0);
        dir_expect(16'h0005, 0, 1'b0, STATUS_LENGTH, 48'd0);
        dir_reg(REG_FEATURE_COUNT, 1);
        dir_reg(REG_EPSILON_SQUARED, APB_DW'(DIST_MAX));
        dir_expect(16'h8000, 0, 1'b0, STATUS_OK, 48'd1073741824);
        dir_reg(REG_CLUSTER_COUNT, 31);
        dir_beat(FUNC_OBSERVE, 0, 0, 16'h1234, 1'b1);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_REG)
                reg_write(dir_rows[i].reg_sel, dir_rows[i].reg_val);
            else
                send(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);
        end

        run_phase(4, 3, DIST_W'($urandom_range(1 << 20)), 0, 0, 1'b0, 120);
        run_phase(16, 32, DIST_W'($urandom_range(1 << 23)), 50, 0, 1'b0, 100);
        run_phase(1, 1, 48'd0, 0, 50, 1'b0, 100);
        run_phase(31, 8, DIST_MAX, 30, 30, 1'b0, 120);
        run_phase(0, 5, DIST_W'({$urandom, $urandom}), 50, 0, 1'b0, 70);
        run_phase(7, 40, DIST_W'($urandom_range(1 << 24)), 0, 50, 1'b0, 80);
        run_phase(3, 2, 48'd262144, 0, 0, 1'b1, 140);
        run_phase(16, 4, DIST_W'($urandom_range(1 << 20)), 30, 30, 1'b0, 90);
        settle();

        $display("%0d beats sent (%0d besides centroid fill) over %0d register settings",
                 n_beats, n_stim, n_settings);
        $display("%0d results checked: %0d assigned, %0d noise, %0d length errors",
                 n_results, n_hits, n_noise, n_len_err);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
